// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/nfds_pkg.sv =====
package nfds_pkg;

    localparam int DIR_W       = 16;
    localparam int PROD_W      = 2 * DIR_W;
    // Three products of two Q1.14 values plus a negation need 34 bits.
    localparam int DOT_W       = PROD_W + 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ORDER_W     = 3;
    localparam int COUNT_W     = 4;
    localparam int S_TDATA_W   = 8 * DIR_W;
    localparam int M_TDATA_W   = 56;
    localparam int M_FIELDS_W  = 2 + ORDER_W + 3 * DIR_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STRENGTH_THR = 3'd0,
        CFG_CHANGE_THR   = 3'd1,
        CFG_USE_CHANGE   = 3'd2,
        CFG_MIN_COSINE   = 3'd3,
        CFG_FIBER_COUNT  = 3'd4
    } cfg_index_t;

    typedef logic signed [DIR_W-1:0] dir_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DOT_W-1:0] dot_t;

endpackage

// ===== design/nearest_fiber_direction_select_core.sv =====
// Nearest fiber direction select. Each input item is one fiber candidate of a voxel; after
// the configured number of candidates (fiber_count, clamped to 1..MAX_FIBERS) one result item
// gives the fiber whose direction, possibly flipped, has the largest dot product with the
// reference direction above min_cosine. One candidate is accepted per clock cycle while input
// is not held off. An item is held in an input register; the dot product, the compare against
// the running best and the load of the output register happen as the item leaves it, so a
// result is offered once the voxel's last candidate has left the input register. Input is
// held off only while a result waits unclaimed in the output register and the next voxel's
// last candidate sits in the input register, and stays held for as long as that wait lasts.
module nearest_fiber_direction_select_core #(
    parameter int MAX_FIBERS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [nfds_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nfds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Candidates.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ref_x, ref_y, ref_z, fiber_strength, fiber_change, dir_x, dir_y, dir_z (16 bits each)
    input  logic [nfds_pkg::S_TDATA_W-1:0]  s_tdata,
    // Results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found[0], best_fiber[3:1], reversed[4], out_x[20:5], out_y[36:21], out_z[52:37], zeros
    output logic [nfds_pkg::M_TDATA_W-1:0]  m_tdata
);
    import nfds_pkg::*;

    localparam int CW = (MAX_FIBERS > 1) ? $clog2(MAX_FIBERS) : 1;
    localparam logic [COUNT_W:0] MAX_COUNT = (COUNT_W + 1)'(MAX_FIBERS);

    // Configuration registers.
    logic [15:0]        strength_thr_reg;
    logic [15:0]        change_thr_reg;
    logic               use_change_reg;
    dir_t               min_cosine_reg;
    logic [COUNT_W-1:0] fiber_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_thr_reg <= '0;
            change_thr_reg   <= '0;
            use_change_reg   <= 1'b0;
            min_cosine_reg   <= 16'sd8192;
            fiber_count_reg  <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_STRENGTH_THR: strength_thr_reg <= cfg_wdata;
                CFG_CHANGE_THR:   change_thr_reg   <= cfg_wdata;
                CFG_USE_CHANGE:   use_change_reg   <= cfg_wdata[0];
                CFG_MIN_COSINE:   min_cosine_reg   <= cfg_wdata;
                CFG_FIBER_COUNT:  fiber_count_reg  <= cfg_wdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pipeline control: everything advances together unless a new result would
    // overwrite one that is still waiting.
    logic v1_reg;
    logic last1_reg;
    logic out_valid_reg;
    logic en;
    logic accept;

    assign en       = !(out_valid_reg && !m_tready && v1_reg && last1_reg);
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // Candidate counter and per-item tags.
    logic [CW-1:0]      ctr_reg, ctr_next;
    logic [COUNT_W:0]   count_eff;
    logic               in_last;
    logic               in_pass;

    always_comb
    begin
        if (fiber_count_reg == '0)
            count_eff = (COUNT_W + 1)'(1);
        else if ({1'b0, fiber_count_reg} > MAX_COUNT)
            count_eff = MAX_COUNT;
        else
            count_eff = {1'b0, fiber_count_reg};
        in_last  = ((COUNT_W + 1)'(ctr_reg) + (COUNT_W + 1)'(1)) >= count_eff;
        ctr_next = in_last ? '0 : ctr_reg + CW'(1);
        in_pass  = (s_tdata[63:48] > strength_thr_reg)
                   && !(use_change_reg && (s_tdata[79:64] <= change_thr_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctr_reg <= '0;
        else if (accept)
            ctr_reg <= ctr_next;
    end

    // Input register.
    dir_t           rx1_reg, ry1_reg, rz1_reg, dx1_reg, dy1_reg, dz1_reg;
    logic           pass1_reg, first1_reg;
    logic [CW-1:0]  order1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            last1_reg <= in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx1_reg    <= s_tdata[15:0];
            ry1_reg    <= s_tdata[31:16];
            rz1_reg    <= s_tdata[47:32];
            dx1_reg    <= s_tdata[95:80];
            dy1_reg    <= s_tdata[111:96];
            dz1_reg    <= s_tdata[127:112];
            pass1_reg  <= in_pass;
            first1_reg <= (ctr_reg == '0);
            order1_reg <= ctr_reg;
        end
    end

    // Running best. The first candidate of a voxel starts from a fresh best;
    // the flipped direction is tried before the direct one.
    prod_t          px, py, pz;
    dot_t           d1;
    dot_t           best_cos_reg, best_cos_next, base_cos, neg_d;
    logic [CW-1:0]  best_order_reg, best_order_next;
    logic           best_flip_reg, best_flip_next;
    logic           found_reg, found_next;
    dir_t           bx_reg, by_reg, bz_reg, bx_next, by_next, bz_next;
    logic           take_neg, take_pos;

    always_comb
    begin
        px              = rx1_reg * dx1_reg;
        py              = ry1_reg * dy1_reg;
        pz              = rz1_reg * dz1_reg;
        d1              = DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
        base_cos        = first1_reg ? dot_t'({{(DOT_W - DIR_W - 14){min_cosine_reg[DIR_W-1]}},
                                               min_cosine_reg, 14'b0})
                                     : best_cos_reg;
        best_order_next = first1_reg ? '0 : best_order_reg;
        best_flip_next  = first1_reg ? 1'b0 : best_flip_reg;
        found_next      = first1_reg ? 1'b0 : found_reg;
        bx_next         = first1_reg ? '0 : bx_reg;
        by_next         = first1_reg ? '0 : by_reg;
        bz_next         = first1_reg ? '0 : bz_reg;
        best_cos_next   = base_cos;
        neg_d           = -d1;
        take_neg        = pass1_reg && (neg_d > base_cos);
        take_pos        = pass1_reg && !take_neg && (d1 > base_cos);
        if (take_neg || take_pos)
        begin
            best_cos_next   = take_neg ? neg_d : d1;
            best_order_next = order1_reg;
            best_flip_next  = take_neg;
            found_next      = 1'b1;
            bx_next         = dx1_reg;
            by_next         = dy1_reg;
            bz_next         = dz1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v1_reg)
        begin
            best_cos_reg   <= best_cos_next;
            best_order_reg <= best_order_next;
            best_flip_reg  <= best_flip_next;
            found_reg      <= found_next;
            bx_reg         <= bx_next;
            by_reg         <= by_next;
            bz_reg         <= bz_next;
        end
    end

    // Output register.
    logic [M_FIELDS_W-1:0] out_fields_reg, out_fields_next;
    dir_t                  ox, oy, oz;

    always_comb
    begin
        ox = best_flip_next ? -bx_next : bx_next;
        oy = best_flip_next ? -by_next : by_next;
        oz = best_flip_next ? -bz_next : bz_next;
        if (found_next)
            out_fields_next = {oz, oy, ox, best_flip_next,
                               ORDER_W'(best_order_next), 1'b1};
        else
            out_fields_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en && v1_reg && last1_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && v1_reg && last1_reg)
            out_fields_reg <= out_fields_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), out_fields_reg};

endmodule

// ===== design/nfds_checker.sv =====
`include "assert_macros.svh"

module nfds_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [nfds_pkg::M_TDATA_W-1:0]  m_tdata
);
    // A result that is not taken stays offered, unchanged.
    `ASSERT_NEXT(a_result_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_result_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // Input is only held off while a result sits unclaimed.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // A voxel without a usable fiber reports all-zero fields.
    `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[52:1] == '0)
endmodule

bind nearest_fiber_direction_select_core nfds_checker u_nfds_checker (.*);
